/* hw/rtl/button_press_duration_classifier_macros.svh */
// ----------------------------------------------------------------------------
// Button press duration classifier: assertion macros
// Shorthands for the concurrent checks at the end of the classifier module.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define BPDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define BPDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bpdc_pkg.sv */
// ----------------------------------------------------------------------------
// bpdc_pkg
// Widths, codes and constants shared by the button classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int MAX_RESULTS = 6;

  localparam int FUNC_W = 2;
  localparam int BTN_W  = 3;
  localparam int US_W   = 32;
  localparam int TIME_W = 23;
  localparam int CFG_W  = 16;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int RECIP_SHIFT = 41;
  localparam logic [US_W-1:0] RECIP_1000 = 32'd2199023256;

  // request kinds
  localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_PRESSED = 2'd0;
  localparam logic [KIND_W-1:0] EV_SHORT   = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  // compare results of the shared age unit
  typedef struct packed {
    logic gt_min;
    logic lt_long;
    logic gt_long;
  } age_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/bpdc_div1000.sv */
// ----------------------------------------------------------------------------
// bpdc_div1000
// Microseconds to milliseconds by reciprocal multiply, product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_div1000 (
  input  wire logic                       clk,
  input  wire logic [bpdc_pkg::US_W-1:0]   tick_us,
  output logic      [bpdc_pkg::TIME_W-1:0] now_q
);
  import bpdc_pkg::*;

  logic [2*US_W-1:0] prod;

  // 32x32 multiply; the quotient always fits the top 23 bits
  always_ff @(posedge clk) begin
    prod <= {{US_W{1'b0}}, tick_us} * {{US_W{1'b0}}, RECIP_1000};
  end

  assign now_q = prod[RECIP_SHIFT +: TIME_W];

endmodule

`default_nettype wire

/* hw/rtl/bpdc_age_unit.sv */
// ----------------------------------------------------------------------------
// bpdc_age_unit
// Shared press-age subtractor and limit comparators.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_age_unit (
  input  wire logic [bpdc_pkg::TIME_W-1:0] now_ms,
  input  wire logic [bpdc_pkg::TIME_W-1:0] press_ms,
  input  wire logic [bpdc_pkg::CFG_W-1:0]  min_press_ms,
  input  wire logic [bpdc_pkg::CFG_W-1:0]  long_press_ms,
  output bpdc_pkg::age_flags_t             flags
);
  import bpdc_pkg::*;

  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] min_ext;
  logic [TIME_W-1:0] long_ext;

  // age wraps modulo 2^23
  assign age      = now_ms - press_ms;
  assign min_ext  = {{(TIME_W-CFG_W){1'b0}}, min_press_ms};
  assign long_ext = {{(TIME_W-CFG_W){1'b0}}, long_press_ms};

  assign flags.gt_min  = age > min_ext;
  assign flags.lt_long = age < long_ext;
  assign flags.gt_long = age > long_ext;

endmodule

`default_nettype wire

/* hw/rtl/button_press_duration_classifier.sv */
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Classifies button presses as pressed / short release / long press events.
// ----------------------------------------------------------------------------
// Usage: one request at a time on the req channel (func 0 press, 1 release,
// 2 tick). A press or release is accepted and then decided in ST_EVAL. A tick
// latches the time on acceptance, runs the registered reciprocal multiply
// that turns microseconds into milliseconds (ST_MUL), captures the new
// millisecond count (ST_NOW), scans the buttons in turn through the single
// shared age/compare unit (ST_SCAN) and releases any held-back final event
// (ST_FLUSH). Work pauses while the event channel holds stall and a new event
// waits for the output register. A tick emits its long-press events in
// ascending button order; the final event of any request carries last = 1.
// req_stall is high for the whole time a request is being worked on.
// Configuration writes are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_duration_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpdc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [bpdc_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [bpdc_pkg::FUNC_W-1:0]    func,
  input  wire logic [bpdc_pkg::BTN_W-1:0]     button,
  input  wire logic [bpdc_pkg::US_W-1:0]      time_us,
  // event channel
  output logic                               evt_valid,
  input  wire logic                          evt_stall,
  output logic      [bpdc_pkg::KIND_W-1:0]    event_kind,
  output logic      [bpdc_pkg::BTN_W-1:0]     event_button,
  output logic                               last
);
  import bpdc_pkg::*;

  `include "button_press_duration_classifier_macros.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;  // press / release decision
  localparam logic [2:0] ST_MUL   = 3'd2;  // reciprocal multiply in flight
  localparam logic [2:0] ST_NOW   = 3'd3;  // capture new millisecond count
  localparam logic [2:0] ST_SCAN  = 3'd4;  // one button per cycle unless a found event waits for output
  localparam logic [2:0] ST_FLUSH = 3'd5;  // release held-back last event

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_BUTTONS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_RESULTS);
  localparam logic [BTN_W+1:0] NUM_BTN_L = (BTN_W+2)'(NUM_BUTTONS);

  // control state
  logic [2:0]             state, state_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic                   is_release;
  logic [NUM_BUTTONS-1:0] held;
  logic                   have_pend;
  logic [CNT_W-1:0]       ev_count;
  logic [CFG_W-1:0]       min_press_ms, long_press_ms;

  // payload
  logic [US_W-1:0]        tick_us;
  logic [TIME_W-1:0]      now_ms;
  logic [TIME_W-1:0]      press_time [NUM_BUTTONS];
  logic [BTN_W-1:0]       pend_btn;

  logic [TIME_W-1:0]      now_q;
  age_flags_t             flags;

  logic                   req_fire, btn_ok;
  logic                   out_free, out_load, out_last_next;
  logic [KIND_W-1:0]      out_kind_next;
  logic [BTN_W-1:0]       out_btn_next, cur_btn;
  logic                   set_held, clr_held, pend_set, pend_clr, cnt_inc;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign btn_ok    = (button != '0) && ({2'b00, button} <= NUM_BTN_L);
  assign cur_btn   = BTN_W'(idx) + BTN_W'(1);

  // output slot can take a new event this cycle
  assign out_free = !evt_valid || !evt_stall;

  bpdc_div1000 u_div (
    .clk     (clk),
    .tick_us (tick_us),
    .now_q   (now_q)
  );

  bpdc_age_unit u_age (
    .now_ms        (now_ms),
    .press_ms      (press_time[idx]),
    .min_press_ms  (min_press_ms),
    .long_press_ms (long_press_ms),
    .flags         (flags)
  );

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    out_load      = 1'b0;
    out_kind_next = EV_LONG;
    out_btn_next  = pend_btn;
    out_last_next = 1'b1;
    set_held      = 1'b0;
    clr_held      = 1'b0;
    pend_set      = 1'b0;
    pend_clr      = 1'b0;
    cnt_inc       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (func == FUNC_TICK) begin
            state_next = ST_MUL;
          end else if ((func == FUNC_PRESS || func == FUNC_RELEASE) && btn_ok) begin
            state_next = ST_EVAL;
            idx_next   = IDX_W'(button - BTN_W'(1));
          end
        end
      end
      ST_EVAL: begin
        out_btn_next = cur_btn;
        if (!is_release) begin
          if (held[idx]) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load      = 1'b1;
            out_kind_next = EV_PRESSED;
            set_held      = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          if (!held[idx] || !flags.gt_min) begin
            state_next = ST_IDLE;
          end else if (!flags.lt_long) begin
            clr_held   = 1'b1;  // long hold released: silent clear
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load      = 1'b1;
            out_kind_next = EV_SHORT;
            clr_held      = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        state_next = ST_NOW;
      end
      ST_NOW: begin
        state_next = ST_SCAN;
        idx_next   = '0;
      end
      ST_SCAN: begin
        if (held[idx] && flags.gt_long) begin
          // events are held back one step so the final one can carry last
          if (!have_pend || out_free) begin
            out_load      = have_pend;
            out_last_next = 1'b0;
            pend_set      = 1'b1;
            clr_held      = 1'b1;
            cnt_inc       = 1'b1;
            if (idx == LAST_IDX || ev_count + CNT_W'(1) == MAX_CNT) begin
              state_next = ST_FLUSH;
            end else begin
              idx_next = idx + IDX_W'(1);
            end
          end
        end else if (idx == LAST_IDX) begin
          state_next = ST_FLUSH;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (!have_pend) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          pend_clr   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      held          <= '0;
      have_pend     <= 1'b0;
      ev_count      <= '0;
      evt_valid     <= 1'b0;
      min_press_ms  <= MIN_PRESS_RST;
      long_press_ms <= LONG_PRESS_RST;
      now_ms        <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (set_held) begin
        held[idx] <= 1'b1;
      end else if (clr_held) begin
        held[idx] <= 1'b0;
      end
      if (pend_set) begin
        have_pend <= 1'b1;
      end else if (pend_clr) begin
        have_pend <= 1'b0;
      end
      if (state == ST_NOW) begin
        ev_count <= '0;
        now_ms   <= now_q;
      end else if (cnt_inc) begin
        ev_count <= ev_count + CNT_W'(1);
      end
      if (out_load) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_MIN_PRESS:  min_press_ms  <= cfg_wdata;
          REG_LONG_PRESS: long_press_ms <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      tick_us    <= time_us;
      is_release <= (func == FUNC_RELEASE);
    end
    if (set_held) begin
      press_time[idx] <= now_ms;
    end
    if (pend_set) begin
      pend_btn <= cur_btn;
    end
    if (out_load) begin
      event_kind   <= out_kind_next;
      event_button <= out_btn_next;
      last         <= out_last_next;
    end
  end

  `BPDC_ASSERT_NOW(a_pend_in_tick, have_pend, (state == ST_SCAN || state == ST_FLUSH), "pending event outside a tick")
  `BPDC_ASSERT_NOW(a_count_cap, 1'b1, (ev_count <= MAX_CNT), "tick event count above limit")
  `BPDC_ASSERT_NOW(a_nonlast_in_scan, (out_load && !out_last_next), (state == ST_SCAN && have_pend), "non-final event outside scan")
  `BPDC_ASSERT_NEXT(a_scan_start, (state == ST_NOW), (state == ST_SCAN && idx == '0 && !have_pend), "scan did not start at button one")

endmodule

`default_nettype wire

/* dv/tb_button_press_duration_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_press_duration_classifier
// Self-checking bench: drives press, release and tick requests, predicts
// the pressed / short-release / long-press events in step with every
// accepted request, and compares each event the block emits field by field.
// ----------------------------------------------------------------------------

module tb_button_press_duration_classifier;
  import bpdc_pkg::*;

  // func 3 is not a defined request kind; the block must drop it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // a tick runs multiply, capture, scan and flush; settle well past that
  localparam int SETTLE_CYCLES  = 24;
  // idle cycles with no handshake on either channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  // one past the largest millisecond count whose microsecond value plus 999 fits 32 bits
  localparam int unsigned MS_WRAP = 32'd4294967;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BTN_W-1:0]  button;
    logic              last;
  } btn_event_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 req_valid;
  logic                 req_stall;
  logic [FUNC_W-1:0]    func;
  logic [BTN_W-1:0]     button;
  logic [US_W-1:0]      time_us;
  logic                 evt_valid;
  logic                 evt_stall;
  logic [KIND_W-1:0]    event_kind;
  logic [BTN_W-1:0]     event_button;
  logic                 last;

  // shadow of the block: per-button press stamp and held flag, current ms
  logic [TIME_W-1:0] press_stamp_ms [NUM_BUTTONS];
  logic              btn_held       [NUM_BUTTONS];
  logic [TIME_W-1:0] now_stamp_ms;
  logic [CFG_W-1:0]  min_ms;
  logic [CFG_W-1:0]  long_ms;

  btn_event_t  expected_events [$];
  int          error_count = 0;

  // stimulus clock in ms, advanced by ticks
  int unsigned stim_ms = 0;

  // idling controls shared by the sender and the event stall process
  bit tx_gaps_on     = 1'b1;
  bit rx_stall_on    = 1'b1;
  int rx_hold_cycles = 0;

  button_press_duration_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .button       (button),
    .time_us      (time_us),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .event_kind   (event_kind),
    .event_button (event_button),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Event prediction: applies one accepted request to the shadow state and
  // queues the events it causes, with last set on the final one.
  // --------------------------------------------------------------------------
  task automatic predict_events(input logic [FUNC_W-1:0] f, input logic [BTN_W-1:0] b,
                                input logic [US_W-1:0] t);
    btn_event_t        evs [MAX_RESULTS];
    int                n;
    int                idx;
    logic [TIME_W-1:0] age;
    n = 0;
    if (f == FUNC_TICK) begin
      now_stamp_ms = TIME_W'(t / 32'd1000);
      // ascending button order, capped at MAX_RESULTS per tick
      for (int i = 0; i < NUM_BUTTONS && n < MAX_RESULTS; i++) begin
        age = now_stamp_ms - press_stamp_ms[i];
        if (btn_held[i] && age > long_ms) begin
          evs[n] = '{EV_LONG, BTN_W'(i + 1), 1'b0};
          n++;
          btn_held[i]       = 1'b0;
          press_stamp_ms[i] = '0;
        end
      end
    end else if ((f == FUNC_PRESS || f == FUNC_RELEASE) && b >= 1 && b <= NUM_BUTTONS) begin
      idx = b - 1;
      age = now_stamp_ms - press_stamp_ms[idx];
      if (f == FUNC_PRESS) begin
        // a press of a held button is dropped and keeps the old stamp
        if (!btn_held[idx]) begin
          btn_held[idx]       = 1'b1;
          press_stamp_ms[idx] = now_stamp_ms;
          evs[n] = '{EV_PRESSED, b, 1'b0};
          n++;
        end
      end else if (btn_held[idx] && age > min_ms) begin
        // too-early releases fall through untouched; at or past the long
        // limit the button clears with no event
        if (age < long_ms) begin
          evs[n] = '{EV_SHORT, b, 1'b0};
          n++;
        end
        btn_held[idx]       = 1'b0;
        press_stamp_ms[idx] = '0;
      end
    end
    for (int k = 0; k < n; k++) begin
      evs[k].last = (k == n - 1);
      expected_events.push_back(evs[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: optional random gap, then hold the request until the
  // block takes it. Fields change only in the step of acceptance or later.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [BTN_W-1:0] b,
                          input logic [US_W-1:0] t);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    button    <= b;
    time_us   <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_events(f, b, t);
  endtask

  // tick at the stimulus clock moved forward by delta ms
  task automatic send_tick(input int unsigned delta);
    stim_ms = (stim_ms + delta) % MS_WRAP;
    send_req(FUNC_TICK, BTN_W'($urandom_range(0, 7)), stim_ms * 1000 + $urandom_range(0, 999));
  endtask

  // sender pauses until every predicted event is out, then the block settles
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both limits are written back to back while the block is idle
  task automatic set_limits(input logic [CFG_W-1:0] min_val, input logic [CFG_W-1:0] long_val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_MIN_PRESS;
    cfg_wdata <= min_val;
    @(posedge clk);
    min_ms = min_val;
    cfg_addr  <= REG_LONG_PRESS;
    cfg_wdata <= long_val;
    @(posedge clk);
    long_ms = long_val;
    cfg_wr_en <= 1'b0;
  endtask

  // one random request: mostly presses, releases and advancing ticks with
  // ages near the limits, plus noise the block must drop
  task automatic send_random_request();
    int unsigned lo;
    int unsigned delta;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_req(FUNC_PRESS, BTN_W'($urandom_range(1, NUM_BUTTONS)), $urandom());
    end else if (pick < 70) begin
      send_req(FUNC_RELEASE, BTN_W'($urandom_range(1, NUM_BUTTONS)), $urandom());
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: delta = $urandom_range(0, min_ms + 2);
        1: begin
          lo    = (long_ms > 2) ? long_ms - 2 : 0;
          delta = $urandom_range(lo, long_ms + 2);
        end
        2: delta = $urandom_range(0, 2 * long_ms + 3);
        default: delta = $urandom_range(0, 3);
      endcase
      send_tick(delta);
    end else if (pick < 94) begin
      // arbitrary time, may jump backward and wrap the age
      send_req(FUNC_TICK, BTN_W'($urandom_range(0, 7)), $urandom());
    end else if ($urandom_range(0, 1)) begin
      send_req(FUNC_UNUSED, BTN_W'($urandom_range(0, 7)), $urandom());
    end else begin
      send_req($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_PRESS,
               $urandom_range(0, 1) ? 3'd0 : 3'd7, $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // edge cases under the reset limits (min 30, long 1000)
  task automatic test_directed_cases();
    send_req(FUNC_PRESS, 3'd0, 32'h0);           // button below range
    send_req(FUNC_RELEASE, 3'd7, 32'hFFFF_FFFF); // button above range
    send_req(FUNC_UNUSED, 3'd1, 32'h0);          // undefined request kind
    send_req(FUNC_TICK, 3'd0, 32'd0);
    send_req(FUNC_PRESS, 3'd1, 32'h0);           // pressed
    send_req(FUNC_PRESS, 3'd1, 32'h0);           // already held: dropped
    send_req(FUNC_RELEASE, 3'd2, 32'h0);         // free button: dropped
    send_req(FUNC_TICK, 3'd7, 32'd10_000);
    send_req(FUNC_RELEASE, 3'd1, 32'h0);         // 10 ms, too early: stays held
    send_req(FUNC_TICK, 3'd3, 32'd31_000);
    send_req(FUNC_RELEASE, 3'd1, 32'h0);         // 31 ms: short release
    send_req(FUNC_PRESS, 3'd6, 32'h0);
    send_req(FUNC_TICK, 3'd6, 32'd1_031_999);    // age exactly long: no event
    send_req(FUNC_RELEASE, 3'd6, 32'h0);         // at long limit: silent clear
    for (int b = 1; b <= NUM_BUTTONS; b++) send_req(FUNC_PRESS, BTN_W'(b), $urandom());
    send_req(FUNC_TICK, 3'd0, 32'hFFFF_FFFF);    // all six long presses at once
    send_req(FUNC_PRESS, 3'd3, 32'h0);
    send_req(FUNC_TICK, 3'd5, 32'd0);            // time goes back: age wraps
    send_req(FUNC_RELEASE, 3'd3, 32'h0);         // cleared already: dropped
    stim_ms = 0;
  endtask

  // receiver stalls for a long stretch while the sender keeps pushing
  // event-heavy requests, so the block fills and stalls its input
  task automatic test_event_backpressure();
    wait_idle();
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = LONG_HOLD;
    while (rx_hold_cycles != 0) @(posedge clk);
    for (int round = 0; round < 4; round++) begin
      for (int b = 1; b <= NUM_BUTTONS; b++) send_req(FUNC_PRESS, BTN_W'(b), $urandom());
      send_tick(long_ms + 5);
    end
    tx_gaps_on = 1'b1;
    wait_idle();
  endtask

  // several limit settings, extremes included, each with random traffic
  task automatic test_limit_sweep();
    logic [CFG_W-1:0] mins  [7] = '{16'd0, 16'hFFFF, 16'd5, 16'd40, 16'd0, 16'hFFFF, 16'd0};
    logic [CFG_W-1:0] longs [7] = '{16'd0, 16'hFFFF, 16'd40, 16'd5, 16'hFFFF, 16'd0, 16'd0};
    // last slot gets a random mid-range setting
    mins[6]  = CFG_W'($urandom_range(0, 200));
    longs[6] = CFG_W'($urandom_range(0, 2000));
    for (int s = 0; s < 7; s++) begin
      set_limits(mins[s], longs[s]);
      repeat (25) send_random_request();
    end
  endtask

  // long random run at the reset limits; the tail runs with no idling
  task automatic test_random_traffic();
    set_limits(MIN_PRESS_RST, LONG_PRESS_RST);
    repeat (80) send_random_request();
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    repeat (40) send_random_request();
  endtask

  // --------------------------------------------------------------------------
  // Event stall: random bursts, quiet stretches, or one long hold counted here
  // --------------------------------------------------------------------------
  initial begin : evt_stall_gen
    int burst;
    evt_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        burst          = rx_hold_cycles;
        rx_hold_cycles = 0;
        evt_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end else if (!rx_stall_on) begin
        evt_stall <= 1'b0;
        @(posedge clk);
      end else begin
        evt_stall <= ($urandom_range(0, 2) == 0);
        burst = $urandom_range(1, 13);
        repeat (burst) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event checker: each accepted event against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin : event_checker
    btn_event_t exp_ev;
    if (!rst && evt_valid && !evt_stall) begin
      if (expected_events.size() == 0) begin
        error_count++;
        $display("%0t: unexpected event, expected none actual kind %0d button %0d last %0d",
                 $time, event_kind, event_button, last);
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("event_kind", exp_ev.kind, event_kind);
        check_field("event_button", exp_ev.button, event_button);
        check_field("last", exp_ev.last, last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (evt_valid && !evt_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired with %0d events outstanding", $time,
             expected_events.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_MIN_PRESS;
    cfg_wdata <= '0;
    req_valid <= 1'b0;
    func      <= FUNC_PRESS;
    button    <= '0;
    time_us   <= '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_stamp_ms[i] = '0;
      btn_held[i]       = 1'b0;
    end
    now_stamp_ms = '0;
    min_ms       = MIN_PRESS_RST;
    long_ms      = LONG_PRESS_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_event_backpressure();
    test_limit_sweep();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bpdc_pkg.sv
hw/rtl/bpdc_div1000.sv
hw/rtl/bpdc_age_unit.sv
hw/rtl/button_press_duration_classifier.sv
dv/tb_button_press_duration_classifier.sv
